// ===== hw/rtl/usbdfu_pkg.sv =====
// Shared types, codes and helpers of the DFU download controller.
package usbdfu_pkg;

	localparam int MAX_BLOCK_BYTES = 1024;

	localparam logic [7:0] REQ_TYPE_MASK  = 8'h7f;
	localparam logic [7:0] REQ_TYPE_DFU   = 8'h21;

	localparam logic [7:0] REQ_DNLOAD     = 8'd1;
	localparam logic [7:0] REQ_GETSTATUS  = 8'd3;
	localparam logic [7:0] REQ_CLRSTATUS  = 8'd4;
	localparam logic [7:0] REQ_GETSTATE   = 8'd5;
	localparam logic [7:0] REQ_ABORT      = 8'd6;

	localparam logic [7:0] CMD_SET_ADDRESS = 8'h21;
	localparam logic [7:0] CMD_PAGE_ERASE  = 8'h41;

	localparam logic [1:0] FLASH_NONE    = 2'd0;
	localparam logic [1:0] FLASH_ERASE   = 2'd1;
	localparam logic [1:0] FLASH_PROGRAM = 2'd2;

	localparam logic [2:0] REPLY_NONE      = 3'd0;
	localparam logic [2:0] REPLY_GETSTATE  = 3'd1;
	localparam logic [2:0] REPLY_GETSTATUS = 3'd6;

	localparam logic [1:0] CFG_TRANSFER_SIZE = 2'd0;
	localparam logic [1:0] CFG_POLL_TIMEOUT  = 2'd1;

	localparam logic [10:0] TRANSFER_SIZE_RESET = 11'd1024;
	localparam logic [23:0] POLL_TIMEOUT_RESET  = 24'd100;

	typedef enum logic [7:0] {
		ST_IDLE         = 8'b0000_0001,
		ST_DNLOAD_SYNC  = 8'b0000_0010,
		ST_DNBUSY       = 8'b0000_0100,
		ST_DNLOAD_IDLE  = 8'b0000_1000,
		ST_MANIFEST_SYNC = 8'b0001_0000,
		ST_MANIFEST     = 8'b0010_0000,
		ST_MANIFEST_WAIT = 8'b0100_0000,
		ST_ERROR        = 8'b1000_0000
	} dfu_state_t;

	typedef struct packed {
		logic        action;
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] block_number;
		logic [10:0] data_length;
		logic [7:0]  command_byte;
		logic [31:0] command_word;
	} req_item_t;

	typedef struct packed {
		logic        handled;
		logic        status_code;
		logic [23:0] poll_timeout;
		logic [3:0]  dfu_state_out;
		logic [2:0]  reply_length;
		logic [1:0]  flash_op;
		logic [31:0] flash_address;
		logic [10:0] program_length;
		logic        reset_request;
	} res_item_t;

	typedef struct packed {
		logic [10:0] transfer_size;
		logic [23:0] busy_poll_timeout;
	} cfg_regs_t;

	// DFU 1.1 state numbering as reported to the host.
	function automatic logic [3:0] state_number(input dfu_state_t st);
		logic [3:0] n;
		case (st)
			ST_IDLE:          n = 4'd2;
			ST_DNLOAD_SYNC:   n = 4'd3;
			ST_DNBUSY:        n = 4'd4;
			ST_DNLOAD_IDLE:   n = 4'd5;
			ST_MANIFEST_SYNC: n = 4'd6;
			ST_MANIFEST:      n = 4'd7;
			ST_MANIFEST_WAIT: n = 4'd8;
			ST_ERROR:         n = 4'd10;
			default:          n = 4'd2;
		endcase
		return n;
	endfunction

endpackage

// ===== hw/rtl/usb_dfu_download_controller.sv =====
// Top level of the DFU download controller: input and result registers.
//
// The block takes one item per clock cycle unless the result side stalls, and
// returns exactly one result per item. The decoder works on the item while it
// sits in the input register; the result register loads its result when the
// item leaves the input register, held while the result side stalls. The
// DFU state and saved download block are updated by the decoder in the same
// cycle the item leaves the input register, so the next item sees them at
// once. The program address uses one 32-by-11-bit multiply and an add in that
// cycle. Configuration is written on a separate port that is always ready and
// takes effect on the next item.
module usb_dfu_download_controller import usbdfu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_item_t   req,
	output logic        res_valid,
	input  logic        res_ready,
	output res_item_t   res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	req_item_t req_s1;
	logic      valid_s1;
	res_item_t res_q;
	logic      res_valid_q;
	res_item_t res_next;
	cfg_regs_t regs;
	logic      advance;
	logic      fire;

	// The result register frees up when it is empty or being taken.
	assign advance = !res_valid_q || res_ready;
	assign fire = valid_s1 && advance;
	assign req_ready = !valid_s1 || advance;

	usbdfu_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	usbdfu_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (req_s1),
		.regs   (regs),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (req_ready)
				valid_s1 <= req_valid;
			if (advance)
				res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			req_s1 <= req;
		if (fire)
			res_q <= res_next;
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

// ===== hw/rtl/usbdfu_cfg_regs.sv =====
// Configuration registers: transfer size and busy poll timeout.
module usbdfu_cfg_regs import usbdfu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output cfg_regs_t   regs
);

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.transfer_size <= TRANSFER_SIZE_RESET;
			regs_q.busy_poll_timeout <= POLL_TIMEOUT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TRANSFER_SIZE: regs_q.transfer_size <= cfg_data[10:0];
				CFG_POLL_TIMEOUT:  regs_q.busy_poll_timeout <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/usbdfu_engine.sv =====
// DFU state machine: holds the protocol state; decodes one item per cycle on fire.
module usbdfu_engine import usbdfu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  req_item_t item,
	input  cfg_regs_t regs,
	output res_item_t res
);

	dfu_state_t  state_q, state_d;
	logic [15:0] saved_block_q, saved_block_d;
	logic [10:0] saved_length_q, saved_length_d;
	logic [7:0]  saved_command_q, saved_command_d;
	logic [31:0] saved_word_q, saved_word_d;
	logic [31:0] base_address_q, base_address_d;
	logic [31:0] block_offset;
	logic [31:0] step;
	logic [10:0] dn_length;

	// Blocks count from 2 at the base; block 1 wraps below the base.
	assign block_offset = {16'b0, saved_block_q} - 32'd2;
	assign step = 32'(block_offset * {21'b0, regs.transfer_size});
	assign dn_length = (item.data_length > 11'(MAX_BLOCK_BYTES)) ?
		11'(MAX_BLOCK_BYTES) : item.data_length;

	always_comb begin
		state_d = state_q;
		saved_block_d = saved_block_q;
		saved_length_d = saved_length_q;
		saved_command_d = saved_command_q;
		saved_word_d = saved_word_q;
		base_address_d = base_address_q;
		res = '0;
		if (!item.action) begin
			if ((item.request_type & REQ_TYPE_MASK) == REQ_TYPE_DFU) begin
				case (item.request_code)
					REQ_DNLOAD: begin
						res.handled = 1'b1;
						if (item.data_length == 11'd0) begin
							state_d = ST_MANIFEST_SYNC;
						end else begin
							saved_block_d = item.block_number;
							saved_length_d = dn_length;
							saved_command_d = item.command_byte;
							saved_word_d = item.command_word;
							state_d = ST_DNLOAD_SYNC;
						end
					end
					REQ_GETSTATUS: begin
						res.handled = 1'b1;
						res.reply_length = REPLY_GETSTATUS;
						if (state_q == ST_DNLOAD_SYNC) begin
							state_d = ST_DNBUSY;
							res.poll_timeout = regs.busy_poll_timeout;
						end else if (state_q == ST_MANIFEST_SYNC) begin
							state_d = ST_MANIFEST;
						end
					end
					REQ_CLRSTATUS: begin
						res.handled = 1'b1;
						if (state_q == ST_ERROR)
							state_d = ST_IDLE;
					end
					REQ_GETSTATE: begin
						res.handled = 1'b1;
						res.reply_length = REPLY_GETSTATE;
					end
					REQ_ABORT: begin
						res.handled = 1'b1;
						state_d = ST_IDLE;
					end
					default: ;
				endcase
			end
		end else if (state_q == ST_DNBUSY) begin
			res.handled = 1'b1;
			state_d = ST_DNLOAD_IDLE;
			if (saved_block_q == 16'd0) begin
				if (saved_command_q == CMD_PAGE_ERASE) begin
					res.flash_op = FLASH_ERASE;
					res.flash_address = saved_word_q;
					base_address_d = saved_word_q;
				end else if (saved_command_q == CMD_SET_ADDRESS) begin
					base_address_d = saved_word_q;
				end
			end else begin
				res.flash_op = FLASH_PROGRAM;
				res.flash_address = base_address_q + step;
				res.program_length = saved_length_q;
			end
		end else if (state_q == ST_MANIFEST) begin
			res.handled = 1'b1;
			res.reset_request = 1'b1;
			state_d = ST_MANIFEST_WAIT;
		end
		res.dfu_state_out = state_number(state_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			saved_block_q <= '0;
			saved_length_q <= '0;
			saved_command_q <= '0;
			saved_word_q <= '0;
			base_address_q <= '0;
		end else if (fire) begin
			state_q <= state_d;
			saved_block_q <= saved_block_d;
			saved_length_q <= saved_length_d;
			saved_command_q <= saved_command_d;
			saved_word_q <= saved_word_d;
			base_address_q <= base_address_d;
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register lost its one-hot code");

	a_unhandled_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !res.handled |=> state_q == $past(state_q))
		else $error("an unhandled item changed the state");

	a_reset_request_wait: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.reset_request |=> state_q == ST_MANIFEST_WAIT)
		else $error("reset request without entering manifest wait");

	a_flash_only_on_event: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.flash_op != FLASH_NONE |-> item.action)
		else $error("flash operation raised by a control request");

endmodule

// ===== test/usb_dfu_download_controller_checker.sv =====
// Result checker for the DFU download controller: predicts every result and compares it.
`timescale 1ns / 100ps

module usb_dfu_download_controller_checker import usbdfu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_item_t   req,
	input  logic        res_valid,
	input  logic        res_ready,
	input  res_item_t   res,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          errors,
	output int          outstanding
);

	// DFU 1.1 state numbers as the host sees them.
	typedef enum logic [3:0] {
		DFU_IDLE          = 4'd2,
		DFU_DNLOAD_SYNC   = 4'd3,
		DFU_DNBUSY        = 4'd4,
		DFU_DNLOAD_IDLE   = 4'd5,
		DFU_MANIFEST_SYNC = 4'd6,
		DFU_MANIFEST      = 4'd7,
		DFU_MANIFEST_WAIT = 4'd8,
		DFU_ERROR         = 4'd10
	} dfu_number_t;

	dfu_number_t dfu_now;
	logic [15:0] block_held;
	logic [10:0] length_held;
	logic [7:0]  command_held;
	logic [31:0] command_word_held;
	logic [31:0] base_addr;
	logic [10:0] xfer_bytes;
	logic [23:0] busy_timeout;

	res_item_t expected_replies[$];

	function automatic res_item_t predict_reply(input req_item_t it);
		res_item_t r;
		logic [31:0] offset;
		r = '0;
		if (!it.action) begin
			if ((it.request_type & REQ_TYPE_MASK) == REQ_TYPE_DFU) begin
				case (it.request_code)
					REQ_DNLOAD: begin
						if (it.data_length == '0) begin
							dfu_now = DFU_MANIFEST_SYNC;
						end else begin
							block_held = it.block_number;
							length_held = (it.data_length > MAX_BLOCK_BYTES) ?
								11'(MAX_BLOCK_BYTES) : it.data_length;
							command_held = it.command_byte;
							command_word_held = it.command_word;
							dfu_now = DFU_DNLOAD_SYNC;
						end
						r.handled = 1'b1;
					end
					REQ_GETSTATUS: begin
						if (dfu_now == DFU_DNLOAD_SYNC) begin
							dfu_now = DFU_DNBUSY;
							r.poll_timeout = busy_timeout;
						end else if (dfu_now == DFU_MANIFEST_SYNC) begin
							dfu_now = DFU_MANIFEST;
						end
						r.reply_length = REPLY_GETSTATUS;
						r.handled = 1'b1;
					end
					REQ_CLRSTATUS: begin
						if (dfu_now == DFU_ERROR)
							dfu_now = DFU_IDLE;
						r.handled = 1'b1;
					end
					REQ_GETSTATE: begin
						r.reply_length = REPLY_GETSTATE;
						r.handled = 1'b1;
					end
					REQ_ABORT: begin
						dfu_now = DFU_IDLE;
						r.handled = 1'b1;
					end
					default: ;
				endcase
			end
		end else if (dfu_now == DFU_DNBUSY) begin
			if (block_held == '0) begin
				if (command_held == CMD_PAGE_ERASE) begin
					r.flash_op = FLASH_ERASE;
					r.flash_address = command_word_held;
					base_addr = command_word_held;
				end else if (command_held == CMD_SET_ADDRESS) begin
					base_addr = command_word_held;
				end
			end else begin
				// Blocks are numbered from 2; block 1 wraps below the base.
				offset = (32'(block_held) - 32'd2) * 32'(xfer_bytes);
				r.flash_op = FLASH_PROGRAM;
				r.flash_address = base_addr + offset;
				r.program_length = length_held;
			end
			dfu_now = DFU_DNLOAD_IDLE;
			r.handled = 1'b1;
		end else if (dfu_now == DFU_MANIFEST) begin
			r.reset_request = 1'b1;
			dfu_now = DFU_MANIFEST_WAIT;
			r.handled = 1'b1;
		end
		r.dfu_state_out = dfu_now;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		if (!arst_n) begin
			dfu_now = DFU_IDLE;
			block_held = '0;
			length_held = '0;
			command_held = '0;
			command_word_held = '0;
			base_addr = '0;
			xfer_bytes = TRANSFER_SIZE_RESET;
			busy_timeout = POLL_TIMEOUT_RESET;
			expected_replies.delete();
			outstanding = 0;
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TRANSFER_SIZE)
					xfer_bytes = cfg_data[10:0];
				else if (cfg_index == CFG_POLL_TIMEOUT)
					busy_timeout = cfg_data;
			end
			if (res_valid && res_ready) begin
				if (expected_replies.size() == 0) begin
					$error("result item arrived with no request pending");
					errors++;
				end else begin
					want = expected_replies.pop_front();
					compare_field("handled", 32'(want.handled), 32'(res.handled));
					compare_field("status_code", 32'(want.status_code),
						32'(res.status_code));
					compare_field("poll_timeout", 32'(want.poll_timeout),
						32'(res.poll_timeout));
					compare_field("dfu_state_out", 32'(want.dfu_state_out),
						32'(res.dfu_state_out));
					compare_field("reply_length", 32'(want.reply_length),
						32'(res.reply_length));
					compare_field("flash_op", 32'(want.flash_op), 32'(res.flash_op));
					compare_field("flash_address", want.flash_address, res.flash_address);
					compare_field("program_length", 32'(want.program_length),
						32'(res.program_length));
					compare_field("reset_request", 32'(want.reset_request),
						32'(res.reset_request));
				end
			end
			if (req_valid && req_ready)
				expected_replies.push_back(predict_reply(req));
			outstanding = expected_replies.size();
		end
	end

endmodule

// ===== test/usb_dfu_download_controller_test.sv =====
// Top of the DFU download controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module usb_dfu_download_controller_test import usbdfu_pkg::*;;

	localparam int QUIET_LIMIT = 2000;
	localparam int ITEM_TARGET = 1100;
	localparam int PHASE_ITEMS = 150;

	// Request codes the block does not support, and register indexes it does not have.
	localparam logic [7:0] REQ_DETACH  = 8'd0;
	localparam logic [7:0] REQ_UPLOAD  = 8'd2;
	localparam logic [7:0] REQ_UNKNOWN = 8'hff;
	localparam logic [1:0] CFG_SPARE   = 2'd2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_item_t   req = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_item_t   res;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	int errors;
	int outstanding;
	int quiet_cycles = 0;
	int items_sent = 0;
	bit calm = 1'b0;

	usb_dfu_download_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	usb_dfu_download_controller_checker reply_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (res_valid && res_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Bit 7 of the request type is the direction and is ignored by the decode.
	function automatic logic [7:0] dfu_type();
		return ($urandom_range(0, 1) != 0) ? (REQ_TYPE_DFU | 8'h80) : REQ_TYPE_DFU;
	endfunction

	function automatic req_item_t dfu_request(input logic [7:0] code, input logic [15:0] blk,
			input logic [10:0] len, input logic [7:0] cmd, input logic [31:0] word);
		req_item_t it;
		it.action = 1'b0;
		it.request_type = dfu_type();
		it.request_code = code;
		it.block_number = blk;
		it.data_length = len;
		it.command_byte = cmd;
		it.command_word = word;
		return it;
	endfunction

	function automatic req_item_t status_event();
		req_item_t it;
		it = req_item_t'({$urandom, $urandom, $urandom});
		it.action = 1'b1;
		return it;
	endfunction

	function automatic req_item_t noise_item();
		req_item_t it;
		it = req_item_t'({$urandom, $urandom, $urandom});
		if ($urandom_range(0, 1) != 0)
			it.request_type = dfu_type();
		if ($urandom_range(0, 1) != 0)
			it.request_code = 8'($urandom_range(0, 7));
		return it;
	endfunction

	function automatic logic [10:0] pick_length();
		case ($urandom_range(0, 9))
			0: return 11'(MAX_BLOCK_BYTES);
			1: return 11'($urandom_range(MAX_BLOCK_BYTES + 1, 2047));
			2: return 11'd1;
			default: return 11'($urandom_range(1, MAX_BLOCK_BYTES));
		endcase
	endfunction

	task automatic put_request(input req_item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	task automatic send_code(input logic [7:0] code);
		put_request(dfu_request(code, 16'($urandom), 11'($urandom), 8'($urandom), $urandom));
	endtask

	// One download block taken through sync, busy and the status-read event.
	task automatic block_transfer(input logic [15:0] blk, input logic [7:0] cmd,
			input logic [31:0] word);
		put_request(dfu_request(REQ_DNLOAD, blk, pick_length(), cmd, word));
		if ($urandom_range(0, 7) == 0)
			put_request(noise_item());
		send_code(REQ_GETSTATUS);
		if ($urandom_range(0, 3) == 0)
			send_code(REQ_GETSTATE);
		put_request(status_event());
		send_code(REQ_GETSTATUS);
	endtask

	task automatic manifest_sequence();
		put_request(dfu_request(REQ_DNLOAD, 16'($urandom), 11'd0, 8'($urandom), $urandom));
		send_code(REQ_GETSTATUS);
		if ($urandom_range(0, 1) != 0)
			send_code(REQ_GETSTATE);
		put_request(status_event());
		send_code(REQ_GETSTATUS);
		if ($urandom_range(0, 1) != 0)
			put_request(status_event());
	endtask

	task automatic download_session();
		logic [15:0] blk;
		logic [7:0] cmd;
		calm = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 1) != 0) begin
			case ($urandom_range(0, 3))
				0: cmd = CMD_SET_ADDRESS;
				1: cmd = 8'($urandom);
				default: cmd = CMD_PAGE_ERASE;
			endcase
			block_transfer(16'd0, cmd, $urandom);
		end
		blk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd2;
		repeat ($urandom_range(1, 6)) begin
			block_transfer(blk, 8'($urandom), $urandom);
			blk++;
		end
		if ($urandom_range(0, 9) < 7)
			manifest_sequence();
		if ($urandom_range(0, 3) == 0)
			send_code(REQ_CLRSTATUS);
		send_code(REQ_ABORT);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and wait until every result is back and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic new_setting(input int phase);
		logic [10:0] xfer;
		logic [23:0] tmo;
		case (phase % 5)
			0: xfer = 11'd64;
			1: xfer = 11'd1024;
			2: xfer = 11'($urandom_range(64, 1024));
			3: xfer = 11'd0;
			default: xfer = 11'h7ff;
		endcase
		case (phase % 3)
			0: tmo = 24'd0;
			1: tmo = 24'hff_ffff;
			default: tmo = 24'($urandom);
		endcase
		settle();
		write_reg(CFG_TRANSFER_SIZE, {13'($urandom), xfer});
		write_reg(CFG_POLL_TIMEOUT, tmo);
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_SPARE + 2'($urandom_range(0, 1)), 24'($urandom));
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 7);
			@(negedge clk);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
		end
	end

	initial begin
		req_item_t it;
		int phase;
		int phase_end;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, with the registers at their reset values.
		send_code(REQ_GETSTATE);
		it = dfu_request(REQ_DNLOAD, 16'd2, 11'd16, 8'h00, 32'h0);
		it.request_type = 8'h22;
		put_request(it);
		it = dfu_request(REQ_GETSTATUS, 16'd0, 11'd0, 8'h00, 32'h0);
		it.request_type = 8'hff;
		put_request(it);
		send_code(REQ_GETSTATUS);
		send_code(REQ_DETACH);
		send_code(REQ_UPLOAD);
		send_code(REQ_UNKNOWN);
		send_code(REQ_CLRSTATUS);
		put_request(status_event());
		block_transfer(16'd0, CMD_PAGE_ERASE, 32'hffff_ffff);
		block_transfer(16'd0, CMD_SET_ADDRESS, 32'h0800_0000);
		block_transfer(16'd0, 8'h55, $urandom);
		// Block 1 with an oversized payload: address wraps below the base.
		put_request(dfu_request(REQ_DNLOAD, 16'd1, 11'h7ff, 8'hff, 32'hffff_ffff));
		send_code(REQ_GETSTATUS);
		put_request(status_event());
		block_transfer(16'hffff, 8'h00, 32'h0);
		put_request(dfu_request(REQ_DNLOAD, 16'd0, 11'd0, 8'h00, 32'h0));
		send_code(REQ_GETSTATUS);
		put_request(status_event());
		send_code(REQ_GETSTATUS);
		put_request(status_event());
		send_code(REQ_CLRSTATUS);
		send_code(REQ_ABORT);

		// Random part, one register setting per phase.
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			new_setting(phase);
			phase++;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
				if ($urandom_range(0, 4) == 0) begin
					calm = ($urandom_range(0, 3) == 0);
					repeat ($urandom_range(1, 6)) put_request(noise_item());
				end else begin
					download_session();
				end
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/usbdfu_pkg.sv
hw/rtl/usbdfu_cfg_regs.sv
hw/rtl/usbdfu_engine.sv
hw/rtl/usb_dfu_download_controller.sv
test/usb_dfu_download_controller_checker.sv
test/usb_dfu_download_controller_test.sv
